/* sv/csrp_pkg.sv */
package csrp_pkg;

  localparam int GAIN_W   = 16;
  localparam int MCAND_W  = 19;
  localparam int PROD_W   = MCAND_W + GAIN_W + 1;
  localparam int CORR_W   = PROD_W + 1;
  localparam int CNT_W    = $clog2(GAIN_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_W - 1);

  localparam int SENSOR_W = 8;
  localparam int SPEED_W  = 16;
  localparam int ERR_W    = SPEED_W + 1;
  localparam int RSUM_W   = SPEED_W + 2;
  localparam int DRIVE_W  = 15;

  localparam int IN_DATA_W  = 3 * SENSOR_W + 3 * SPEED_W;
  localparam int OUT_DATA_W = ((2 * DRIVE_W + 7) / 8) * 8;

  localparam logic [SENSOR_W-1:0]        LOST_LEVEL  = 8'd30;
  localparam logic [SENSOR_W-1:0]        LINE_CENTER = 8'd200;
  localparam logic [SENSOR_W+1:0]        WEAK_SUM    = 10'd10;
  localparam logic signed [RSUM_W-1:0]   GYRO_OFFSET = 18'sd15;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WHEEL_KP       = 3'd0,
    REG_WHEEL_KI       = 3'd1,
    REG_WHEEL_KD       = 3'd2,
    REG_RATE_KP        = 3'd3,
    REG_RATE_KD        = 3'd4,
    REG_STEER_KP       = 3'd5,
    REG_BASE_SPEED     = 3'd6,
    REG_STOP_WHEN_LOST = 3'd7
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0] WHEEL_KP_RESET = 16'd10240;
  localparam logic [GAIN_W-1:0] WHEEL_KI_RESET = 16'd3072;
  localparam logic [GAIN_W-1:0] WHEEL_KD_RESET = 16'd10240;
  localparam logic [GAIN_W-1:0] RATE_KP_RESET  = 16'd51;
  localparam logic [GAIN_W-1:0] RATE_KD_RESET  = 16'd10;
  localparam logic [GAIN_W-1:0] STEER_KP_RESET = 16'd0;

  typedef struct packed {
    logic load;
    logic step;
    logic sum;
    logic update;
  } wheel_ctrl_t;

endpackage

/* sv/csrp_serial_mul.sv */
module csrp_serial_mul (
  input  logic                                clk,
  input  logic                                load,
  input  logic                                step,
  input  logic signed [csrp_pkg::MCAND_W-1:0] mcand,
  input  logic [csrp_pkg::GAIN_W-1:0]         gain,
  output logic signed [csrp_pkg::PROD_W-1:0]  product
);

  localparam int MC_W = csrp_pkg::MCAND_W;
  localparam int G_W  = csrp_pkg::GAIN_W;
  localparam int HI_W = MC_W + 1;

  logic signed [MC_W-1:0] mc;
  logic signed [HI_W-1:0] hi;
  logic [G_W-1:0]         lo;
  logic signed [HI_W-1:0] addend;
  logic signed [HI_W-1:0] sum;

  // one multiplier bit per cycle while step is high, lsb first, product shifts into lo
  always_comb begin
    addend = lo[0] ? HI_W'(mc) : '0;
    sum    = hi + addend;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mc <= mcand;
      hi <= '0;
      lo <= gain;
    end else if (step) begin
      hi <= {sum[HI_W-1], sum[HI_W-1:1]};
      lo <= {sum[0], lo[G_W-1:1]};
    end
  end

  assign product = {hi, lo};

endmodule

/* sv/csrp_wheel.sv */
module csrp_wheel #(
  parameter int DRIVE_LIMIT        = 10000,
  parameter int GAIN_FRACTION_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  csrp_pkg::wheel_ctrl_t               ctrl,
  input  logic signed [csrp_pkg::SPEED_W-1:0] target,
  input  logic signed [csrp_pkg::SPEED_W-1:0] encoder,
  input  logic [csrp_pkg::GAIN_W-1:0]         kp,
  input  logic [csrp_pkg::GAIN_W-1:0]         ki,
  input  logic [csrp_pkg::GAIN_W-1:0]         kd,
  output logic signed [csrp_pkg::DRIVE_W-1:0] drive
);

  localparam int MC_W    = csrp_pkg::MCAND_W;
  localparam int E_W     = csrp_pkg::ERR_W;
  localparam int P_W     = csrp_pkg::PROD_W;
  localparam int D_W     = csrp_pkg::DRIVE_W;
  localparam longint LIMIT_Q = longint'(DRIVE_LIMIT) << GAIN_FRACTION_BITS;
  localparam int ACC_W   = $clog2(LIMIT_Q + 1) + 1;
  localparam int INC_W   = P_W + 2;
  localparam int SUM_W   = (INC_W > ACC_W ? INC_W : ACC_W) + 1;
  localparam int Q_W     = (ACC_W > D_W ? ACC_W : D_W);
  localparam logic signed [SUM_W-1:0] LIM_HI = SUM_W'(LIMIT_Q);
  localparam logic signed [SUM_W-1:0] LIM_LO = -LIM_HI;

  logic signed [E_W-1:0]   e0;
  logic signed [E_W-1:0]   e1;
  logic signed [E_W-1:0]   e2;
  logic signed [MC_W-1:0]  mc_p;
  logic signed [MC_W-1:0]  mc_i;
  logic signed [MC_W-1:0]  mc_d;
  logic signed [P_W-1:0]   prod_p;
  logic signed [P_W-1:0]   prod_i;
  logic signed [P_W-1:0]   prod_d;
  logic signed [INC_W-1:0] inc;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [SUM_W-1:0] acc_sum;
  logic signed [Q_W-1:0]   acc_x;
  logic signed [Q_W-1:0]   acc_q;

  always_comb begin
    e0   = E_W'(target) - E_W'(encoder);
    mc_p = MC_W'(e0) - MC_W'(e1);
    mc_i = MC_W'(e0);
    mc_d = MC_W'(e0) - (MC_W'(e1) <<< 1) + MC_W'(e2);
  end

  csrp_serial_mul u_mul_p (
    .clk     (clk),
    .load    (ctrl.load),
    .step    (ctrl.step),
    .mcand   (mc_p),
    .gain    (kp),
    .product (prod_p)
  );

  csrp_serial_mul u_mul_i (
    .clk     (clk),
    .load    (ctrl.load),
    .step    (ctrl.step),
    .mcand   (mc_i),
    .gain    (ki),
    .product (prod_i)
  );

  csrp_serial_mul u_mul_d (
    .clk     (clk),
    .load    (ctrl.load),
    .step    (ctrl.step),
    .mcand   (mc_d),
    .gain    (kd),
    .product (prod_d)
  );

  always_comb begin
    acc_sum = SUM_W'(acc) + SUM_W'(inc);
    if (acc_sum > LIM_HI) begin
      acc_next = ACC_W'(LIM_HI);
    end else if (acc_sum < LIM_LO) begin
      acc_next = ACC_W'(LIM_LO);
    end else begin
      acc_next = ACC_W'(acc_sum);
    end
  end

  // truncate toward zero
  always_comb begin
    acc_x = Q_W'(acc);
    acc_q = acc_x >>> GAIN_FRACTION_BITS;
    if (acc[ACC_W-1] && (acc[GAIN_FRACTION_BITS-1:0] != '0)) begin
      acc_q = acc_q + Q_W'(1);
    end
  end

  assign drive = acc_q[D_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      e1  <= '0;
      e2  <= '0;
      acc <= '0;
    end else begin
      if (ctrl.load) begin
        e1 <= e0;
        e2 <= e1;
      end
      if (ctrl.update) begin
        acc <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum) begin
      inc <= INC_W'(prod_p) + INC_W'(prod_i) + INC_W'(prod_d);
    end
  end

  a_acc_bounded: assert property (@(posedge clk) disable iff (rst)
    (SUM_W'(acc) <= LIM_HI) && (SUM_W'(acc) >= LIM_LO))
    else $error("wheel accumulator beyond drive limit");

endmodule

/* sv/cascaded_steer_rate_speed_pid_top.sv */
// cascaded steering / yaw-rate / wheel-speed controller for a two-wheel robot
//
// s_axis: one beat per control tick carrying the three line sensors, the gyro
//   rate and both measured wheel speeds. m_axis: one beat per tick carrying
//   the left and right motor drives. cfg: register writes (index, data), always
//   ready; write only while no tick is in flight.
//
// each tick runs three passes through bit-serial multipliers:
//   steering gain, then rate p and d in parallel, then the six wheel pid
//   products in parallel. a new input beat is taken only after the previous
//   tick's result has moved to the output register.
//
// reset restores the default gains, clears the loop history and accumulators,
//   and treats the previous sensors as lost-line.
// when m_axis stalls, a finished result waits in the output register; the next
//   tick is accepted and computed, then holds until the output register frees,
//   and s_axis_tready stays low until then.
module cascaded_steer_rate_speed_pid_top #(
  parameter int DRIVE_LIMIT        = 10000,
  parameter int GAIN_FRACTION_BITS = 10
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // sensor_left, sensor_middle, sensor_right, gyro_rate, encoder_left, encoder_right
  input  logic [csrp_pkg::IN_DATA_W-1:0]          s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // drive_left, drive_right, zero fill
  output logic [csrp_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [csrp_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [csrp_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int MC_W     = csrp_pkg::MCAND_W;
  localparam int P_W      = csrp_pkg::PROD_W;
  localparam int G_W      = csrp_pkg::GAIN_W;
  localparam int SPD_W    = csrp_pkg::SPEED_W;
  localparam int SNS_W    = csrp_pkg::SENSOR_W;
  localparam int E_W      = csrp_pkg::ERR_W;
  localparam int RS_W     = csrp_pkg::RSUM_W;
  localparam int CR_W     = csrp_pkg::CORR_W;
  localparam int D_W      = csrp_pkg::DRIVE_W;
  localparam int PAD_W    = csrp_pkg::OUT_DATA_W - 2 * D_W;
  localparam int BASE_Q_W = SPD_W + GAIN_FRACTION_BITS;
  localparam int TS_W     = (BASE_Q_W > CR_W ? BASE_Q_W : CR_W) + 1;

  localparam logic signed [TS_W-1:0] TS_MAX   = TS_W'(32767);
  localparam logic signed [TS_W-1:0] TS_MIN   = TS_W'(-32768);
  localparam logic signed [RS_W-1:0] RERR_MAX = RS_W'(65535);
  localparam logic signed [RS_W-1:0] RERR_MIN = RS_W'(-65536);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEER,
    ST_TARGET,
    ST_RATE,
    ST_RATE_MUL,
    ST_CORR,
    ST_SPLIT,
    ST_WHEEL_LOAD,
    ST_WHEEL_MUL,
    ST_WHEEL_SUM,
    ST_WHEEL_ACC,
    ST_DONE
  } state_t;

  state_t state;
  logic [csrp_pkg::CNT_W-1:0] cnt;

  logic [G_W-1:0]          wheel_kp;
  logic [G_W-1:0]          wheel_ki;
  logic [G_W-1:0]          wheel_kd;
  logic [G_W-1:0]          rate_kp;
  logic [G_W-1:0]          rate_kd;
  logic [G_W-1:0]          steer_kp;
  logic signed [SPD_W-1:0] base_speed;
  logic                    stop_when_lost;

  logic [SNS_W-1:0]        sensor_left;
  logic [SNS_W-1:0]        sensor_middle;
  logic [SNS_W-1:0]        sensor_right;
  logic signed [SPD_W-1:0] gyro_in;
  logic signed [SPD_W-1:0] enc_left_in;
  logic signed [SPD_W-1:0] enc_right_in;

  logic                    accept;
  logic                    cnt_end;
  logic                    prev_lost;
  logic signed [SPD_W-1:0] base_sel;
  logic signed [SPD_W-1:0] gyro;
  logic signed [SPD_W-1:0] enc_left;
  logic signed [SPD_W-1:0] enc_right;
  logic signed [SPD_W-1:0] target;
  logic signed [E_W-1:0]   prev_rerr;
  logic signed [CR_W-1:0]  corr;
  logic signed [SPD_W-1:0] target_left;
  logic signed [SPD_W-1:0] target_right;

  logic [SNS_W+1:0]        sense_sum;
  logic [SNS_W-1:0]        mid;
  logic [SNS_W-1:0]        mag;
  logic signed [MC_W-1:0]  mag_x;
  logic signed [MC_W-1:0]  steer_err;
  logic signed [RS_W-1:0]  rate_sum;
  logic signed [E_W-1:0]   rerr;
  logic signed [RS_W-1:0]  rdiff;
  logic signed [TS_W-1:0]  base_q;
  logic signed [TS_W-1:0]  sum_left;
  logic signed [TS_W-1:0]  sum_right;

  logic                    load_a;
  logic                    step_a;
  logic                    load_b;
  logic                    step_b;
  logic signed [MC_W-1:0]  mc_a;
  logic signed [MC_W-1:0]  mc_b;
  logic [G_W-1:0]          gain_a;
  logic signed [P_W-1:0]   prod_a;
  logic signed [P_W-1:0]   prod_b;

  csrp_pkg::wheel_ctrl_t   wctrl;
  logic signed [D_W-1:0]   drive_left;
  logic signed [D_W-1:0]   drive_right;

  function automatic logic signed [SPD_W-1:0] trunc_sat(input logic signed [TS_W-1:0] v);
    logic signed [TS_W-1:0] q;
    q = v >>> GAIN_FRACTION_BITS;
    if (v[TS_W-1] && (v[GAIN_FRACTION_BITS-1:0] != '0)) begin
      q = q + TS_W'(1);
    end
    if (q > TS_MAX) begin
      return TS_MAX[SPD_W-1:0];
    end else if (q < TS_MIN) begin
      return TS_MIN[SPD_W-1:0];
    end
    return q[SPD_W-1:0];
  endfunction

  assign sensor_left   = s_axis_tdata[SNS_W-1:0];
  assign sensor_middle = s_axis_tdata[2*SNS_W-1:SNS_W];
  assign sensor_right  = s_axis_tdata[3*SNS_W-1:2*SNS_W];
  assign gyro_in       = s_axis_tdata[3*SNS_W+SPD_W-1:3*SNS_W];
  assign enc_left_in   = s_axis_tdata[3*SNS_W+2*SPD_W-1:3*SNS_W+SPD_W];
  assign enc_right_in  = s_axis_tdata[3*SNS_W+3*SPD_W-1:3*SNS_W+2*SPD_W];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign cnt_end       = (cnt == csrp_pkg::CNT_LAST);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_kp       <= csrp_pkg::WHEEL_KP_RESET;
      wheel_ki       <= csrp_pkg::WHEEL_KI_RESET;
      wheel_kd       <= csrp_pkg::WHEEL_KD_RESET;
      rate_kp        <= csrp_pkg::RATE_KP_RESET;
      rate_kd        <= csrp_pkg::RATE_KD_RESET;
      steer_kp       <= csrp_pkg::STEER_KP_RESET;
      base_speed     <= '0;
      stop_when_lost <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (csrp_pkg::cfg_reg_t'(cfg_index))
        csrp_pkg::REG_WHEEL_KP:       wheel_kp       <= cfg_data;
        csrp_pkg::REG_WHEEL_KI:       wheel_ki       <= cfg_data;
        csrp_pkg::REG_WHEEL_KD:       wheel_kd       <= cfg_data;
        csrp_pkg::REG_RATE_KP:        rate_kp        <= cfg_data;
        csrp_pkg::REG_RATE_KD:        rate_kd        <= cfg_data;
        csrp_pkg::REG_STEER_KP:       steer_kp       <= cfg_data;
        csrp_pkg::REG_BASE_SPEED:     base_speed     <= cfg_data;
        csrp_pkg::REG_STOP_WHEN_LOST: stop_when_lost <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // line error from the incoming beat
  always_comb begin
    sense_sum = (SNS_W+2)'(sensor_left) + (SNS_W+2)'(sensor_middle)
              + (SNS_W+2)'(sensor_right);
    mid       = (sensor_middle > csrp_pkg::LINE_CENTER) ? csrp_pkg::LINE_CENTER
                                                         : sensor_middle;
    mag       = csrp_pkg::LINE_CENTER - mid;
    mag_x     = MC_W'(mag);
    if ((sense_sum > csrp_pkg::WEAK_SUM) && (sensor_left != sensor_right)) begin
      steer_err = (sensor_left > sensor_right) ? mag_x : -mag_x;
    end else begin
      steer_err = '0;
    end
  end

  // rate error and its change
  always_comb begin
    rate_sum = RS_W'(target) - RS_W'(gyro) - csrp_pkg::GYRO_OFFSET;
    if (rate_sum < RERR_MIN) begin
      rerr = RERR_MIN[E_W-1:0];
    end else if (rate_sum > RERR_MAX) begin
      rerr = RERR_MAX[E_W-1:0];
    end else begin
      rerr = rate_sum[E_W-1:0];
    end
    rdiff = RS_W'(rerr) - RS_W'(prev_rerr);
  end

  always_comb begin
    base_q    = TS_W'(base_sel) <<< GAIN_FRACTION_BITS;
    sum_left  = base_q + TS_W'(corr);
    sum_right = base_q - TS_W'(corr);
  end

  always_comb begin
    load_a = accept || (state == ST_RATE);
    step_a = (state == ST_STEER) || (state == ST_RATE_MUL);
    load_b = (state == ST_RATE);
    step_b = (state == ST_RATE_MUL);
    mc_b   = MC_W'(rdiff);
    if (state == ST_IDLE) begin
      mc_a   = steer_err;
      gain_a = steer_kp;
    end else begin
      mc_a   = MC_W'(rerr);
      gain_a = rate_kp;
    end
    wctrl.load   = (state == ST_WHEEL_LOAD);
    wctrl.step   = (state == ST_WHEEL_MUL);
    wctrl.sum    = (state == ST_WHEEL_SUM);
    wctrl.update = (state == ST_WHEEL_ACC);
  end

  csrp_serial_mul u_mul_a (
    .clk     (clk),
    .load    (load_a),
    .step    (step_a),
    .mcand   (mc_a),
    .gain    (gain_a),
    .product (prod_a)
  );

  csrp_serial_mul u_mul_b (
    .clk     (clk),
    .load    (load_b),
    .step    (step_b),
    .mcand   (mc_b),
    .gain    (rate_kd),
    .product (prod_b)
  );

  csrp_wheel #(
    .DRIVE_LIMIT        (DRIVE_LIMIT),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_wheel_left (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (wctrl),
    .target  (target_left),
    .encoder (enc_left),
    .kp      (wheel_kp),
    .ki      (wheel_ki),
    .kd      (wheel_kd),
    .drive   (drive_left)
  );

  csrp_wheel #(
    .DRIVE_LIMIT        (DRIVE_LIMIT),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_wheel_right (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (wctrl),
    .target  (target_right),
    .encoder (enc_right),
    .kp      (wheel_kp),
    .ki      (wheel_ki),
    .kd      (wheel_kd),
    .drive   (drive_right)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
      prev_lost     <= 1'b1;
      prev_rerr     <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            base_sel  <= (stop_when_lost && prev_lost) ? '0 : base_speed;
            prev_lost <= (sensor_left < csrp_pkg::LOST_LEVEL)
                      && (sensor_middle < csrp_pkg::LOST_LEVEL)
                      && (sensor_right < csrp_pkg::LOST_LEVEL);
            gyro      <= gyro_in;
            enc_left  <= enc_left_in;
            enc_right <= enc_right_in;
            state     <= ST_STEER;
          end
        end
        ST_STEER: begin
          if (cnt_end) begin
            cnt   <= '0;
            state <= ST_TARGET;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_TARGET: begin
          target <= trunc_sat(TS_W'(prod_a));
          state  <= ST_RATE;
        end
        ST_RATE: begin
          prev_rerr <= rerr;
          state     <= ST_RATE_MUL;
        end
        ST_RATE_MUL: begin
          if (cnt_end) begin
            cnt   <= '0;
            state <= ST_CORR;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_CORR: begin
          corr  <= CR_W'(prod_a) + CR_W'(prod_b);
          state <= ST_SPLIT;
        end
        ST_SPLIT: begin
          target_left  <= trunc_sat(sum_left);
          target_right <= trunc_sat(sum_right);
          state        <= ST_WHEEL_LOAD;
        end
        ST_WHEEL_LOAD: begin
          state <= ST_WHEEL_MUL;
        end
        ST_WHEEL_MUL: begin
          if (cnt_end) begin
            cnt   <= '0;
            state <= ST_WHEEL_SUM;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_WHEEL_SUM: begin
          state <= ST_WHEEL_ACC;
        end
        ST_WHEEL_ACC: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {{PAD_W{1'b0}}, drive_right, drive_left};
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_STEER))
    else $error("accepted beat did not start the steering pass");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside the done step");

  a_idle_count_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (cnt == '0))
    else $error("bit counter not cleared between ticks");

  a_done_drains: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && !m_axis_tvalid) |=> (m_axis_tvalid && (state == ST_IDLE)))
    else $error("finished result not moved to the output register");

endmodule

/* test/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FRAC_ONE    = 1024;
  localparam longint ACC_LIMIT   = 10000 * 1024;
  localparam int     QUIET_LIMIT = 4000;
  localparam int     HOLD_CYCLES = 400;
  localparam int     RAND_TICKS  = 140;
  localparam int     LAST_PHASE  = 6;

  typedef struct packed {
    logic signed [15:0] enc_r;
    logic signed [15:0] enc_l;
    logic signed [15:0] gyro;
    logic [7:0]         sens_r;
    logic [7:0]         sens_m;
    logic [7:0]         sens_l;
  } tick_t;

  typedef struct packed {
    logic [1:0]         pad;
    logic signed [14:0] right;
    logic signed [14:0] left;
  } drive_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [csrp_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [csrp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [csrp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [csrp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  cascaded_steer_rate_speed_pid_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // controller copy: gains and loop history
  logic [15:0] wheel_kp = csrp_pkg::WHEEL_KP_RESET;
  logic [15:0] wheel_ki = csrp_pkg::WHEEL_KI_RESET;
  logic [15:0] wheel_kd = csrp_pkg::WHEEL_KD_RESET;
  logic [15:0] rate_kp = csrp_pkg::RATE_KP_RESET;
  logic [15:0] rate_kd = csrp_pkg::RATE_KD_RESET;
  logic [15:0] steer_kp = csrp_pkg::STEER_KP_RESET;
  logic signed [15:0] base_speed = '0;
  logic stop_when_lost = 1'b0;
  logic [7:0] last_sensors [3] = '{default: 8'd0};
  longint last_rate_err = 0;
  longint err_hist [2][2] = '{default: 0};
  longint drive_acc [2] = '{default: 0};

  tick_t tick_q[$];
  drive_pair_t pending_drives[$];
  logic in_taken = 1'b0;
  int ticks_queued = 0;
  int ticks_accepted = 0;
  int drives_checked = 0;
  int cfg_writes = 0;
  int input_stalls = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  logic hold_arm = 1'b0;
  logic hold_done = 1'b0;

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint wheel_step(int side, longint tgt, longint meas);
    longint e0, e1, e2, inc;
    e0 = tgt - meas;
    e1 = err_hist[side][0];
    e2 = err_hist[side][1];
    inc = (e0 - e1) * longint'(wheel_kp) + e0 * longint'(wheel_ki)
        + (e0 - 2 * e1 + e2) * longint'(wheel_kd);
    err_hist[side][1] = e1;
    err_hist[side][0] = e0;
    drive_acc[side] = sat(drive_acc[side] + inc, -ACC_LIMIT, ACC_LIMIT);
    return drive_acc[side] / FRAC_ONE;
  endfunction

  function automatic drive_pair_t predict_drives(tick_t t);
    drive_pair_t d;
    longint base, mid, line_err, rate_tgt, rerr, corr, tgt_l, tgt_r;
    int unsigned sum;
    if (stop_when_lost && last_sensors[0] < csrp_pkg::LOST_LEVEL
        && last_sensors[1] < csrp_pkg::LOST_LEVEL
        && last_sensors[2] < csrp_pkg::LOST_LEVEL)
      base = 0;
    else
      base = longint'(base_speed);
    last_sensors[0] = t.sens_l;
    last_sensors[1] = t.sens_m;
    last_sensors[2] = t.sens_r;

    mid = (t.sens_m > csrp_pkg::LINE_CENTER) ? longint'(csrp_pkg::LINE_CENTER)
                                             : longint'(t.sens_m);
    sum = int'(t.sens_l) + int'(t.sens_m) + int'(t.sens_r);
    if (sum > csrp_pkg::WEAK_SUM && t.sens_l != t.sens_r)
      line_err = (t.sens_l > t.sens_r) ? longint'(csrp_pkg::LINE_CENTER) - mid
                                       : mid - longint'(csrp_pkg::LINE_CENTER);
    else
      line_err = 0;

    rate_tgt = sat(longint'(steer_kp) * line_err / FRAC_ONE, -32768, 32767);
    rerr = sat(rate_tgt - (longint'($signed(t.gyro)) + longint'(csrp_pkg::GYRO_OFFSET)),
               -65536, 65535);
    corr = longint'(rate_kp) * rerr + longint'(rate_kd) * (rerr - last_rate_err);
    last_rate_err = rerr;

    tgt_l = sat((base * FRAC_ONE + corr) / FRAC_ONE, -32768, 32767);
    tgt_r = sat((base * FRAC_ONE - corr) / FRAC_ONE, -32768, 32767);

    d.pad = '0;
    d.left = 15'(wheel_step(0, tgt_l, longint'($signed(t.enc_l))));
    d.right = 15'(wheel_step(1, tgt_r, longint'($signed(t.enc_r))));
    return d;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata <= tick_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    drive_pair_t want, got;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (csrp_pkg::cfg_reg_t'(cfg_index))
          csrp_pkg::REG_WHEEL_KP:       wheel_kp = cfg_data;
          csrp_pkg::REG_WHEEL_KI:       wheel_ki = cfg_data;
          csrp_pkg::REG_WHEEL_KD:       wheel_kd = cfg_data;
          csrp_pkg::REG_RATE_KP:        rate_kp = cfg_data;
          csrp_pkg::REG_RATE_KD:        rate_kd = cfg_data;
          csrp_pkg::REG_STEER_KP:       steer_kp = cfg_data;
          csrp_pkg::REG_BASE_SPEED:     base_speed = cfg_data;
          csrp_pkg::REG_STOP_WHEN_LOST: stop_when_lost = cfg_data[0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_drives.size() == 0) begin
          $error("drive beat with no tick outstanding");
          errors++;
        end else begin
          want = pending_drives.pop_front();
          drives_checked++;
          if (got.left !== want.left) begin
            $error("drive_left mismatch: expected %0d, got %0d", want.left, got.left);
            errors++;
          end
          if (got.right !== want.right) begin
            $error("drive_right mismatch: expected %0d, got %0d", want.right, got.right);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_drives.push_back(predict_drives(tick_t'(s_axis_tdata)));
        ticks_accepted++;
      end
      if (s_axis_tvalid && !s_axis_tready)
        input_stalls++;
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(csrp_pkg::cfg_reg_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure_phase(int p);
    logic [15:0] g [6];
    logic [15:0] base;
    logic stop;
    case (p)
      0: begin
        g = '{16'd10240, 16'd3072, 16'd10240, 16'd51, 16'd10, 16'd1024};
        base = 16'd300;
        stop = 1'b1;
      end
      1: begin
        g = '{default: 16'hFFFF};
        base = 16'h7FFF;
        stop = 1'b0;
      end
      2: begin
        g = '{default: 16'h0000};
        base = 16'h8000;
        stop = 1'b1;
      end
      3: begin
        g = '{csrp_pkg::WHEEL_KP_RESET, csrp_pkg::WHEEL_KI_RESET, csrp_pkg::WHEEL_KD_RESET,
              csrp_pkg::RATE_KP_RESET, csrp_pkg::RATE_KD_RESET, 16'd4096};
        base = 16'd1000;
        stop = 1'b1;
      end
      default: begin
        foreach (g[i])
          g[i] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(12000));
        base = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(4000) - 2000);
        stop = 1'($urandom_range(1));
      end
    endcase
    write_reg(csrp_pkg::REG_WHEEL_KP, g[0]);
    write_reg(csrp_pkg::REG_WHEEL_KI, g[1]);
    write_reg(csrp_pkg::REG_WHEEL_KD, g[2]);
    write_reg(csrp_pkg::REG_RATE_KP, g[3]);
    write_reg(csrp_pkg::REG_RATE_KD, g[4]);
    write_reg(csrp_pkg::REG_STEER_KP, g[5]);
    write_reg(csrp_pkg::REG_BASE_SPEED, base);
    write_reg(csrp_pkg::REG_STOP_WHEN_LOST, {15'd0, stop});
  endtask

  task automatic queue_tick(logic [7:0] l, logic [7:0] m, logic [7:0] r,
                            logic [15:0] gyro, logic [15:0] enc_l, logic [15:0] enc_r);
    tick_t t;
    t.sens_l = l;
    t.sens_m = m;
    t.sens_r = r;
    t.gyro = gyro;
    t.enc_l = enc_l;
    t.enc_r = enc_r;
    tick_q.push_back(t);
    ticks_queued++;
  endtask

  function automatic logic [15:0] rand_speed();
    if ($urandom_range(4) == 0)
      return 16'($urandom);
    return 16'($urandom_range(3000) - 1500);
  endfunction

  task automatic queue_random_tick();
    int pick;
    logic [7:0] l, m, r;
    pick = $urandom_range(99);
    if (pick < 12) begin
      // lost line
      l = 8'($urandom_range(29));
      m = 8'($urandom_range(29));
      r = 8'($urandom_range(29));
    end else if (pick < 18) begin
      // weak line, sum at most 10
      l = 8'($urandom_range(4));
      m = 8'($urandom_range(3));
      r = 8'($urandom_range(3));
    end else if (pick < 28) begin
      l = 8'($urandom_range(255));
      m = 8'($urandom_range(255));
      r = l;
    end else if (pick < 45) begin
      l = 8'($urandom_range(255));
      m = 8'($urandom_range(255));
      r = 8'($urandom_range(255));
    end else begin
      // on the line, middle sensor bright
      l = 8'($urandom_range(120));
      m = 8'($urandom_range(255, 80));
      r = 8'($urandom_range(120));
    end
    queue_tick(l, m, r, rand_speed(), rand_speed(), rand_speed());
  endtask

  task automatic wait_drained();
    while (!(ticks_accepted == ticks_queued && pending_drives.size() == 0))
      @(negedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    configure_phase(0);
    @(posedge clk);
    // lost-line stop right after reset, weak line, sign and clamp of the line error
    queue_tick(8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    queue_tick(8'd20, 8'd10, 8'd25, 16'd0, 16'd0, 16'd0);
    queue_tick(8'd100, 8'd50, 8'd40, 16'd0, 16'd10, 16'd10);
    queue_tick(8'd40, 8'd50, 8'd100, 16'd5, 16'd20, 16'd20);
    queue_tick(8'd100, 8'd80, 8'd100, 16'd0, 16'd300, 16'd300);
    queue_tick(8'd4, 8'd3, 8'd3, 16'd0, 16'd0, 16'd0);
    queue_tick(8'd4, 8'd4, 8'd3, 16'd0, 16'd0, 16'd0);
    queue_tick(8'd255, 8'd255, 8'd0, 16'hFFF1, 16'd0, 16'd0);
    queue_tick(8'd0, 8'd0, 8'd255, 16'd0, 16'd0, 16'd0);
    queue_tick(8'd29, 8'd29, 8'd29, 16'd0, 16'd0, 16'd0);
    queue_tick(8'd30, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    queue_tick(8'd10, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    queue_tick(8'd150, 8'd200, 8'd50, 16'h7FFF, 16'd0, 16'd0);
    queue_tick(8'd50, 8'd201, 8'd150, 16'h8000, 16'd0, 16'd0);
    queue_tick(8'd120, 8'd90, 8'd60, 16'd0, 16'h7FFF, 16'h8000);
    queue_tick(8'd60, 8'd90, 8'd120, 16'd0, 16'h8000, 16'h7FFF);
    queue_tick(8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_tick(8'd200, 8'd0, 8'd1, 16'h8000, 16'h8000, 16'h8000);
    queue_tick(8'd200, 8'd0, 8'd1, 16'h8000, 16'h8000, 16'h8000);
    queue_tick(8'd1, 8'd0, 8'd200, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    queue_tick(8'd1, 8'd0, 8'd200, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    queue_tick(8'd128, 8'd128, 8'd127, 16'h5555, 16'hAAAA, 16'h5555);
    wait_drained();

    for (int p = 1; p <= LAST_PHASE; p++) begin
      configure_phase(p);
      @(posedge clk);
      case (p)
        2: begin send_idle_pct = 46; recv_stall_pct = 0; end
        3: begin send_idle_pct = 0; recv_stall_pct = 46; end
        4, 6: begin send_idle_pct = 10; recv_stall_pct = 10; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (p == 5)
        hold_arm <= 1'b1;
      repeat (RAND_TICKS) queue_random_tick();
      wait_drained();
    end

    repeat (60) @(negedge clk);
    $display("%0d control ticks checked as %0d drive beats across %0d gain settings (%0d writes)",
             ticks_accepted, drives_checked, LAST_PHASE + 1, cfg_writes);
    $display("idle and stall mixes plus one %0d-cycle output hold; input held off %0d cycles",
             HOLD_CYCLES, input_stalls);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
